/* sv/assert_macros.svh */
// Assertion macros shared by the checker files of the scanner.
// Each macro samples on clk; the first one is masked while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off during reset.
`define MBPS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("scanner assertion failed");

// Concurrent assertion that is also checked during and right after reset.
`define MBPS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("scanner assertion failed");

`endif

/* sv/mbps_pkg.sv */
// Package of the masked byte pattern scanner: item types, register
// indexes and fixed widths. Used by the interfaces, the top level and the checker.
`default_nettype none

package mbps_pkg;

  // Fixed pattern storage: four 64-bit registers hold 32 pattern bytes.
  localparam int PAT_BYTES  = 32;
  localparam int PAT_REGS   = 4;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int LEN_REG_W  = 6;
  localparam int ADDR_W     = 64;
  localparam int COUNT_W    = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7    = 3'd0,
    REG_PAT_8_15   = 3'd1,
    REG_PAT_16_23  = 3'd2,
    REG_PAT_24_31  = 3'd3,
    REG_CARE_MASK  = 3'd4,
    REG_PAT_LENGTH = 3'd5,
    REG_REGION     = 3'd6
  } reg_index_t;

  // One input item: a byte of the region and its end marker.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic               match_found;
    logic [ADDR_W-1:0]  match_address;
    logic               scan_done;
    logic [COUNT_W-1:0] total_matches;
  } out_item_t;

endpackage

`default_nettype wire

/* sv/mbps_stream_if.sv */
// Valid/ready channel interfaces of the scanner, one per item type.
// Depends on mbps_pkg for the payload structs.
`default_nettype none

interface mbps_in_if;
  logic               valid;
  logic               ready;
  mbps_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mbps_out_if;
  logic                valid;
  logic                ready;
  mbps_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* sv/masked_byte_pattern_scanner.sv */
// Masked byte pattern scanner, top level.
// Depends on mbps_pkg and the channel interfaces in mbps_stream_if.sv.
//
// The scanner takes one region byte per clock and reports every place where
// a pattern of up to 32 bytes, with per-byte wildcards, ends fully inside the
// region. The byte window, the length select and the per-position compare sit
// in front of a first register, so each byte is judged in the cycle it is
// accepted; a second register adds region_base to the match offset. A new
// byte is taken every cycle while results flow. Only matching bytes and the
// region's last byte produce a result; the last one carries scan_done and the
// saturating match count, and the region state then starts over.
// Configuration may be written only while no item is in flight.
`default_nettype none

module masked_byte_pattern_scanner #(
  parameter int PATTERN_MAX = 32,
  parameter int OFFSET_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  mbps_in_if.sink                                  stream,
  mbps_out_if.source                               report,
  input  wire logic                                cfg_write,
  input  wire logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int LEN_W     = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W     = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LEN_EXT_W = mbps_pkg::LEN_REG_W + 1;

  // Configuration registers.
  logic [mbps_pkg::PAT_REGS-1:0][mbps_pkg::CFG_DATA_W-1:0] pattern_regs;
  logic [mbps_pkg::PAT_BYTES-1:0]                          care_mask;
  logic [mbps_pkg::LEN_REG_W-1:0]                          pattern_length;
  logic [mbps_pkg::ADDR_W-1:0]                             region_base;

  // Region state. Window entry 0 is the newest byte.
  logic [PATTERN_MAX-1:0][7:0]   byte_window;
  logic [PATTERN_MAX-1:0][7:0]   window_next;
  logic [OFFSET_BITS-1:0]        bytes_seen;
  logic [OFFSET_BITS-1:0]        bytes_seen_next;
  logic [mbps_pkg::COUNT_W-1:0]  match_counter;
  logic [mbps_pkg::COUNT_W-1:0]  match_counter_next;

  // Compare stage signals.
  logic [LEN_EXT_W-1:0]   len_ext;
  logic [LEN_EXT_W-1:0]   len_sel;
  logic [LEN_W-1:0]       len_used;
  logic [PATTERN_MAX-1:0] pos_ok;
  logic                   span_full;
  logic                   hit;
  logic [OFFSET_BITS-1:0] offset_next;

  // First stage register.
  logic                          s1_valid;
  logic                          s1_found;
  logic                          s1_last;
  logic [OFFSET_BITS-1:0]        s1_offset;
  logic [mbps_pkg::COUNT_W-1:0]  s1_count;

  // Output register and handshake.
  logic                  out_valid;
  mbps_pkg::out_item_t   out_item;
  logic                  out_load;
  logic                  s1_emit;
  logic                  s1_free;
  logic                  accept;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_regs   <= '0;
      care_mask      <= '1;
      pattern_length <= mbps_pkg::LEN_REG_W'(1);
      region_base    <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        mbps_pkg::REG_PAT_0_7:    pattern_regs[0] <= cfg_data;
        mbps_pkg::REG_PAT_8_15:   pattern_regs[1] <= cfg_data;
        mbps_pkg::REG_PAT_16_23:  pattern_regs[2] <= cfg_data;
        mbps_pkg::REG_PAT_24_31:  pattern_regs[3] <= cfg_data;
        mbps_pkg::REG_CARE_MASK:  care_mask <= cfg_data[mbps_pkg::PAT_BYTES-1:0];
        mbps_pkg::REG_PAT_LENGTH: pattern_length <= cfg_data[mbps_pkg::LEN_REG_W-1:0];
        mbps_pkg::REG_REGION:     region_base <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow: an item without a result leaves stage one at once.
  assign out_load     = !out_valid || report.ready;
  assign s1_emit      = s1_valid && (s1_found || s1_last);
  assign s1_free      = !s1_valid || !s1_emit || out_load;
  assign accept       = stream.valid && s1_free;
  assign stream.ready = s1_free;

  // Shift the new byte into the window.
  assign window_next[0] = stream.payload.data_byte;
  for (genvar k = 1; k < PATTERN_MAX; k++) begin : g_shift
    assign window_next[k] = byte_window[k-1];
  end

  // Pattern length in use: zero reads as one, large values clip.
  always_comb begin
    len_ext = {1'b0, pattern_length};
    if (pattern_length == '0) begin
      len_sel = LEN_EXT_W'(1);
    end else if (len_ext > LEN_EXT_W'(PATTERN_MAX)) begin
      len_sel = LEN_EXT_W'(PATTERN_MAX);
    end else begin
      len_sel = len_ext;
    end
    len_used = len_sel[LEN_W-1:0];
  end

  // Per-position compare; pattern position i sits len-1-i bytes back.
  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    if (i < mbps_pkg::PAT_BYTES) begin : g_cared
      logic [LEN_W-1:0] back;
      assign back = len_used - LEN_W'(i + 1);
      assign pos_ok[i] = (LEN_W'(i) >= len_used) || !care_mask[i] ||
                         (window_next[back[IDX_W-1:0]] ==
                          pattern_regs[i/8][(i%8)*8 +: 8]);
    end else begin : g_wild
      // Positions past the pattern storage are wildcards.
      assign pos_ok[i] = 1'b1;
    end
  end

  // Byte count, match decision and start offset.
  always_comb begin
    bytes_seen_next = (bytes_seen == '1) ? bytes_seen : bytes_seen + 1'b1;
    span_full       = bytes_seen_next >= OFFSET_BITS'(len_used);
    hit             = span_full && (&pos_ok);
    offset_next     = bytes_seen_next - OFFSET_BITS'(len_used);
    if (hit && (match_counter != '1)) begin
      match_counter_next = match_counter + 1'b1;
    end else begin
      match_counter_next = match_counter;
    end
  end

  // Window contents outside the counted span are never compared.
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_window <= window_next;
    end
  end

  // Region counters; the last byte starts a fresh region.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen    <= '0;
      match_counter <= '0;
    end else if (accept) begin
      if (stream.payload.last_byte) begin
        bytes_seen    <= '0;
        match_counter <= '0;
      end else begin
        bytes_seen    <= bytes_seen_next;
        match_counter <= match_counter_next;
      end
    end
  end

  // Stage one register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_found  <= hit;
      s1_last   <= stream.payload.last_byte;
      s1_offset <= offset_next;
      s1_count  <= match_counter_next;
    end
  end

  // Output register: adds the region base to the match offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_emit) begin
      out_item.match_found   <= s1_found;
      out_item.match_address <= s1_found ?
                                region_base + mbps_pkg::ADDR_W'(s1_offset) : '0;
      out_item.scan_done     <= s1_last;
      out_item.total_matches <= s1_count;
    end
  end

  assign report.valid   = out_valid;
  assign report.payload = out_item;

endmodule

`default_nettype wire

/* sv/mbps_checker.sv */
// Port-level checker of the masked byte pattern scanner and its bind.
// Depends on mbps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mbps_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire mbps_pkg::out_item_t out_payload
);

  // A stalled result keeps its contents.
  `MBPS_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_payload))

  // No result is shown in the cycle after reset.
  `MBPS_ASSERT_ALWAYS(a_reset_quiet, $past(rst) |-> !out_valid)

  // A result without a match carries a zero address.
  `MBPS_ASSERT(a_nomatch_addr, out_valid && !out_payload.match_found |-> out_payload.match_address == '0)

  // A match is always counted.
  `MBPS_ASSERT(a_match_counted, out_valid && out_payload.match_found |-> out_payload.total_matches != '0)

  // Every result is either a match or the end of a region.
  `MBPS_ASSERT(a_result_reason, out_valid |-> out_payload.match_found || out_payload.scan_done)

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (report.valid),
  .out_ready   (report.ready),
  .out_payload (report.payload)
);

`default_nettype wire

/* verif/tb.sv */
// Testbench for masked_byte_pattern_scanner: a directed script followed by random regions,
// checked field by field against a scan predictor in the bench or results typed into the script.
// Depends on mbps_pkg, the channel interfaces in mbps_stream_if.sv and the scanner top level.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbps_pkg::*;

  localparam int WIN_BYTES    = 32;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 800;
  localparam int HOLD_CYCLES  = 80;
  localparam int SCRIPT_LEN   = 30;

  // What a script step does and how its result is known.
  typedef enum logic [1:0] {
    STEP_WRITE,      // register write
    STEP_SCAN,       // byte, result taken from the predictor
    STEP_NO_REPORT,  // byte that must give no result
    STEP_REPORT      // byte with the result typed into the script
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    reg_index_t  reg_sel;
    logic [63:0] value;
    logic [7:0]  data;
    logic        last;
    out_item_t   report;
  } script_step_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mbps_in_if  byte_in();
  mbps_out_if match_out();

  masked_byte_pattern_scanner uut (
    .clk       (clk),
    .rst       (rst),
    .stream    (byte_in),
    .report    (match_out),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the configuration registers, at their reset values.
  logic [63:0] pat_reg [PAT_REGS] = '{default: '0};
  logic [31:0] care_bits = '1;
  logic [5:0]  len_field = 6'd1;
  logic [63:0] region_addr = '0;

  // Scan state of the predictor.
  logic [7:0]  scan_win [WIN_BYTES] = '{default: '0};
  logic [31:0] scan_seen = '0;
  logic [31:0] scan_hits = '0;

  out_item_t pending_reports [$];
  int mismatches = 0;
  int bytes_sent = 0;
  int burst_left = 0;

  // Side information that travels with the byte on offer.
  step_kind_t offer_kind = STEP_SCAN;
  out_item_t  offer_typed = '0;

  // Receiver hold-off control.
  bit pressure_on = 1'b0;
  bit pressure_used = 1'b0;
  int hold_left = 0;
  int tick = 0;
  logic [15:0] ready_pat = '1;

  // Directed script: after reset, wildcards, wrap of the address, short regions,
  // clamped lengths and the extremes of the byte values.
  script_step_t script [SCRIPT_LEN] = '{
    '{STEP_REPORT, REG_PAT_0_7, 64'd0, 8'h00, 1'b0, '{1'b1, 64'd0, 1'b0, 32'd1}},
    '{STEP_REPORT, REG_PAT_0_7, 64'd0, 8'hFF, 1'b1, '{1'b0, 64'd0, 1'b1, 32'd1}},
    '{STEP_REPORT, REG_PAT_0_7, 64'd0, 8'hFF, 1'b1, '{1'b0, 64'd0, 1'b1, 32'd0}},
    '{STEP_WRITE, REG_PAT_0_7, 64'h0000_0000_EFBE_ADDE, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_CARE_MASK, 64'h0000_0000_FFFF_FFFD, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_PAT_LENGTH, 64'd4, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_REGION, 64'hFFFF_FFFF_FFFF_FFFE, 8'h00, 1'b0, '0},
    '{STEP_NO_REPORT, REG_PAT_0_7, 64'd0, 8'hDE, 1'b0, '0},
    '{STEP_NO_REPORT, REG_PAT_0_7, 64'd0, 8'h00, 1'b0, '0},
    '{STEP_NO_REPORT, REG_PAT_0_7, 64'd0, 8'hBE, 1'b0, '0},
    '{STEP_REPORT, REG_PAT_0_7, 64'd0, 8'hEF, 1'b0,
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 32'd1}},
    '{STEP_SCAN, REG_PAT_0_7, 64'd0, 8'hDE, 1'b0, '0},
    '{STEP_SCAN, REG_PAT_0_7, 64'd0, 8'h55, 1'b0, '0},
    '{STEP_SCAN, REG_PAT_0_7, 64'd0, 8'hBE, 1'b0, '0},
    '{STEP_SCAN, REG_PAT_0_7, 64'd0, 8'hEF, 1'b1, '0},
    '{STEP_NO_REPORT, REG_PAT_0_7, 64'd0, 8'hDE, 1'b0, '0},
    '{STEP_NO_REPORT, REG_PAT_0_7, 64'd0, 8'hAD, 1'b0, '0},
    '{STEP_REPORT, REG_PAT_0_7, 64'd0, 8'hBE, 1'b1, '{1'b0, 64'd0, 1'b1, 32'd0}},
    '{STEP_WRITE, REG_PAT_LENGTH, 64'd0, 8'h00, 1'b0, '0},
    '{STEP_SCAN, REG_PAT_0_7, 64'd0, 8'hDE, 1'b1, '0},
    '{STEP_WRITE, REG_PAT_LENGTH, 64'd63, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_CARE_MASK, 64'd0, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_REGION, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, '0},
    '{STEP_NO_REPORT, REG_PAT_0_7, 64'd0, 8'hFF, 1'b0, '0},
    '{STEP_REPORT, REG_PAT_0_7, 64'd0, 8'h00, 1'b1, '{1'b0, 64'd0, 1'b1, 32'd0}},
    '{STEP_WRITE, REG_PAT_0_7, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_PAT_LENGTH, 64'd1, 8'h00, 1'b0, '0},
    '{STEP_WRITE, REG_CARE_MASK, 64'h0000_0000_FFFF_FFFF, 8'h00, 1'b0, '0},
    '{STEP_REPORT, REG_PAT_0_7, 64'd0, 8'hFF, 1'b0,
      '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 32'd1}},
    '{STEP_REPORT, REG_PAT_0_7, 64'd0, 8'hFF, 1'b1, '{1'b1, 64'd0, 1'b1, 32'd2}}
  };

  function automatic logic [7:0] pat_byte(input int i);
    return pat_reg[i / 8][(i % 8) * 8 +: 8];
  endfunction

  // Pattern positions in use: zero counts as one, the window size is the ceiling.
  function automatic int used_len();
    if (len_field == 6'd0) return 1;
    if (int'(len_field) > WIN_BYTES) return WIN_BYTES;
    return int'(len_field);
  endfunction

  // Moves one byte into the scan window and works out the result it causes.
  function automatic void scan_byte(input logic [7:0] b, input logic last,
                                    output bit has, output out_item_t res);
    int len;
    bit hit;
    logic [63:0] addr;
    len = used_len();
    for (int k = WIN_BYTES - 1; k > 0; k--) scan_win[k] = scan_win[k-1];
    scan_win[0] = b;
    if (scan_seen != '1) scan_seen++;
    hit = (scan_seen >= 32'(len));
    // Position i of the span is the i-th oldest of the last len bytes.
    for (int i = 0; i < len; i++) begin
      if (care_bits[i] && pat_byte(i) != scan_win[len-1-i]) hit = 1'b0;
    end
    addr = '0;
    if (hit) begin
      addr = region_addr + 64'(scan_seen) - 64'(len);
      if (scan_hits != '1) scan_hits++;
    end
    has = hit || last;
    res = '{match_found: hit, match_address: addr, scan_done: last,
            total_matches: scan_hits};
    // The region state starts over after its last byte.
    if (last) begin
      scan_win = '{default: '0};
      scan_seen = '0;
      scan_hits = '0;
    end
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // Writes one register and keeps the shadow copy in step.
  task automatic write_reg(input reg_index_t idx, input logic [63:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx) inside
      REG_PAT_0_7, REG_PAT_8_15, REG_PAT_16_23, REG_PAT_24_31: pat_reg[int'(idx)] = value;
      REG_CARE_MASK: care_bits = value[31:0];
      REG_PAT_LENGTH: len_field = value[5:0];
      REG_REGION: region_addr = value;
      default: ;
    endcase
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one byte, in bursts with random gaps, and returns once it is taken.
  task automatic send_byte(input step_kind_t kind, input logic [7:0] b, input logic last,
                           input out_item_t typed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if ($urandom_range(0, 19) == 0) gap = 25;
      if (gap != 0) begin
        byte_in.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_in.valid <= 1'b1;
    byte_in.payload <= '{data_byte: b, last_byte: last};
    offer_kind <= kind;
    offer_typed <= typed;
    do @(posedge clk); while (!byte_in.ready);
    bytes_sent++;
  endtask

  // Stops offering and waits until every expected result is in and the pipe is empty.
  task automatic settle();
    byte_in.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Predict on every accepted byte, then check every accepted result.
  always @(posedge clk) begin : scoreboard
    bit has;
    out_item_t res;
    out_item_t want;
    if (!rst && byte_in.valid && byte_in.ready) begin
      scan_byte(byte_in.payload.data_byte, byte_in.payload.last_byte, has, res);
      if (offer_kind == STEP_REPORT) begin
        pending_reports = {pending_reports, offer_typed};
      end else if (offer_kind == STEP_SCAN && has) begin
        pending_reports = {pending_reports, res};
      end
    end
    if (!rst && match_out.valid && match_out.ready) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("result arrived with none expected");
      end else begin
        want = pending_reports.pop_front();
        if (match_out.payload.match_found !== want.match_found)
          flag_mismatch($sformatf("match_found %b, expected %b",
                                  match_out.payload.match_found, want.match_found));
        if (match_out.payload.match_address !== want.match_address)
          flag_mismatch($sformatf("match_address %h, expected %h",
                                  match_out.payload.match_address, want.match_address));
        if (match_out.payload.scan_done !== want.scan_done)
          flag_mismatch($sformatf("scan_done %b, expected %b",
                                  match_out.payload.scan_done, want.scan_done));
        if (match_out.payload.total_matches !== want.total_matches)
          flag_mismatch($sformatf("total_matches %0d, expected %0d",
                                  match_out.payload.total_matches, want.total_matches));
      end
    end
  end

  // Receiver: a rotating stall pattern whose mode changes now and then, plus one
  // long hold-off whenever a pressure phase starts.
  always @(posedge clk) begin
    tick <= tick + 1;
    if (tick % 97 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pat <= '1;
        1: ready_pat <= 16'($urandom);
        2: ready_pat <= 16'($urandom & $urandom);
        default: ready_pat <= 16'($urandom | $urandom);
      endcase
    end else begin
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
    end
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      match_out.ready <= 1'b0;
    end else if (pressure_on && !pressure_used) begin
      hold_left <= HOLD_CYCLES;
      pressure_used <= 1'b1;
      match_out.ready <= 1'b0;
    end else begin
      if (!pressure_on) pressure_used <= 1'b0;
      match_out.ready <= ready_pat[0];
    end
  end

  // Main sequence: reset, directed script, then random phases.
  initial begin
    int goal;
    int phase;
    int eff;
    int n;
    int pos;
    int regions;
    bit pressure;
    bit small_alpha;
    bit finish_region;
    logic [63:0] v;
    logic [7:0] alpha [4];
    logic [7:0] region_bytes [128];

    rst <= 1'b1;
    cfg_write <= 1'b0;
    cfg_index <= REG_PAT_0_7;
    cfg_data <= '0;
    byte_in.valid <= 1'b0;
    byte_in.payload <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[s]) begin
      if (script[s].kind == STEP_WRITE) begin
        settle();
        write_reg(script[s].reg_sel, script[s].value);
      end else begin
        send_byte(script[s].kind, script[s].data, script[s].last, script[s].report);
      end
    end

    goal = bytes_sent + RANDOM_BYTES;
    phase = 0;
    while (bytes_sent < goal) begin
      pressure = (phase == 1) || (phase % 6 == 4);
      small_alpha = ($urandom_range(0, 2) == 0);
      foreach (alpha[a]) alpha[a] = 8'($urandom);
      settle();

      // Pattern registers: zeros, ones, random, or drawn from a small alphabet.
      for (int r = 0; r < PAT_REGS; r++) begin
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = '1;
          default: v = {$urandom, $urandom};
        endcase
        if (small_alpha) begin
          for (int k = 0; k < 8; k++) v[k*8 +: 8] = alpha[$urandom_range(0, 3)];
        end
        write_reg(reg_index_t'(int'(REG_PAT_0_7) + r), v);
      end

      case ($urandom_range(0, 7))
        0: v = '0;
        1, 2: v = 64'h0000_0000_FFFF_FFFF;
        3: v = 64'($urandom & $urandom);
        default: v = 64'($urandom);
      endcase
      if (pressure) v = '0;
      write_reg(REG_CARE_MASK, v);

      case ($urandom_range(0, 9))
        0: v = 64'd0;
        1: v = 64'd32;
        2: v = 64'($urandom_range(33, 63));
        3: v = 64'($urandom_range(9, 31));
        default: v = 64'($urandom_range(1, 8));
      endcase
      if (pressure) v = 64'($urandom_range(1, 4));
      write_reg(REG_PAT_LENGTH, v);

      case ($urandom_range(0, 5))
        0: v = '0;
        1: v = '1;
        2: v = 64'd0 - 64'($urandom_range(1, 64));
        default: v = {$urandom, $urandom};
      endcase
      write_reg(REG_REGION, v);

      eff = used_len();
      pressure_on <= pressure;
      regions = pressure ? 3 : $urandom_range(2, 6);
      for (int g = 0; g < regions; g++) begin
        case ($urandom_range(0, 7))
          0: n = $urandom_range(1, eff);
          1: n = $urandom_range(eff, eff + 64);
          default: n = $urandom_range(eff, eff + 8);
        endcase
        if (pressure) n = $urandom_range(30, 50);
        for (int i = 0; i < n; i++)
          region_bytes[i] = small_alpha ? alpha[$urandom_range(0, 3)] : 8'($urandom);

        // Most regions carry planted copies of the pattern, often at the last fit.
        if ($urandom_range(0, 4) != 0 && n >= eff) begin
          repeat ($urandom_range(1, 3)) begin
            pos = ($urandom_range(0, 2) == 0) ? n - eff : $urandom_range(0, n - eff);
            for (int k = 0; k < eff; k++) begin
              if (care_bits[k]) region_bytes[pos + k] = pat_byte(k);
            end
          end
          // Sometimes flip one bit of a random byte of the region, which may break a copy.
          if ($urandom_range(0, 3) == 0)
            region_bytes[$urandom_range(0, n - 1)] ^= 8'(1 << $urandom_range(0, 7));
        end

        // The final region of a phase is now and then left open across the next writes.
        finish_region = !(g == regions - 1 && $urandom_range(0, 7) == 0);
        for (int i = 0; i < n; i++)
          send_byte(STEP_SCAN, region_bytes[i], finish_region && i == n - 1, '0);
      end
      pressure_on <= 1'b0;
      phase++;
    end

    settle();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

/* files.f */
+incdir+sv
sv/mbps_pkg.sv
sv/mbps_stream_if.sv
sv/masked_byte_pattern_scanner.sv
sv/mbps_checker.sv
verif/tb.sv
